// ----- hw/rtl/multi_stack_shared_pool_defines.svh -----
// Assertion macros used by the multi-stack pool top level.
`ifndef MULTI_STACK_SHARED_POOL_DEFINES_SVH
`define MULTI_STACK_SHARED_POOL_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define MSSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define MSSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MSSP_ASSERT(lbl, prop, msg)
`define MSSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/mssp_pkg.sv -----
// Types and constants of the multi-stack shared pool.
package mssp_pkg;

  localparam int FUNC_W   = 1;
  localparam int SN_W     = 11;
  localparam int VAL_W    = 14;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACKS   = 1'b1;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_STACK = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_MISMATCH  = 3'd4,
    STAT_IGNORED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_TOP,
    ST_POP,
    ST_DONE
  } state_t;

  // Pool memory controls from the sequencer.
  typedef struct packed {
    logic wr_en;
    logic wr_value;
  } pool_ctl_t;

endpackage

// ----- hw/rtl/mssp_if.sv -----
// Valid/ready channel interfaces for items and results.
interface mssp_in_if;
  logic                          valid;
  logic                          ready;
  logic [mssp_pkg::FUNC_W-1:0]   func;
  logic [mssp_pkg::SN_W-1:0]     stack_number;
  logic [mssp_pkg::VAL_W-1:0]    item_value;

  modport source (output valid, output func, output stack_number, output item_value,
                  input ready);
  modport sink (input valid, input func, input stack_number, input item_value,
                output ready);
endinterface

interface mssp_out_if;
  logic                          valid;
  logic                          ready;
  logic [mssp_pkg::STAT_W-1:0]   status;
  logic [mssp_pkg::CNT_W-1:0]    occupancy;
  logic [mssp_pkg::CNT_W-1:0]    peak_occupancy;
  logic                          error_latched;
  logic                          clean_finish;

  modport source (output valid, output status, output occupancy, output peak_occupancy,
                  output error_latched, output clean_finish, input ready);
  modport sink (input valid, input status, input occupancy, input peak_occupancy,
                input error_latched, input clean_finish, output ready);
endinterface

// ----- hw/rtl/mssp_pool.sv -----
// Shared entry pool: value and link-below memories, one write and one read port.
module mssp_pool #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int PW    = 11
) (
  input  logic                          clk,
  input  mssp_pkg::pool_ctl_t           ctl,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [mssp_pkg::VAL_W-1:0]    wr_value,
  input  logic [PW-1:0]                 wr_below,
  input  logic [AW-1:0]                 rd_addr,
  output logic [mssp_pkg::VAL_W-1:0]    rd_value,
  output logic [PW-1:0]                 rd_below
);

  logic [mssp_pkg::VAL_W-1:0] value_mem [DEPTH];
  logic [PW-1:0]              below_mem [DEPTH];

  // link is written on both push and pop, value on push only
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      below_mem[wr_addr] <= wr_below;
      if (ctl.wr_value) begin
        value_mem[wr_addr] <= wr_value;
      end
    end
    rd_value <= value_mem[rd_addr];
    rd_below <= below_mem[rd_addr];
  end

endmodule

// ----- hw/rtl/multi_stack_shared_pool.sv -----
// Top level: several LIFO stacks linked through one shared, capacity-limited pool.
//
//  channel  | dir | transaction holds
//  ---------+-----+------------------------------------------------------------
//  in_chan  | in  | func, stack_number, item_value
//  out_chan | out | status, occupancy, peak_occupancy, error_latched, clean_finish
//  cfg_*    | in  | cfg_index, cfg_wdata on cfg_we (capacity_limit, stacks_in_use)
//
//  States: CHECK -> DONE for a bad stack, full pool or ignored item, CHECK -> TOP -> DONE
//   for a push or empty-stack pop, CHECK -> TOP -> POP -> DONE for other pops, then IDLE. Set
//   by the head read -> pool read -> head/pool write chain through registered-read memories.
//  Reset: head table swept to the empty marker, one stack a cycle over all STACK_COUNT stacks,
//   with in_chan.ready low; configuration writes are taken meanwhile.
//  Stalls: DONE holds only while the result register is full and out_chan.ready is low.
`include "multi_stack_shared_pool_defines.svh"

module multi_stack_shared_pool #(
  parameter int STACK_COUNT = 1024,
  parameter int POOL_DEPTH  = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mssp_in_if.sink                           in_chan,
  mssp_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [mssp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mssp_pkg::CFG_W-1:0]        cfg_wdata
);

  // stack index, pool address, and pool pointer (address plus empty marker) widths
  localparam int SW = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int PW = $clog2(POOL_DEPTH + 1);
  localparam logic [PW-1:0] EMPTY   = PW'(POOL_DEPTH);
  localparam logic [SW-1:0] LAST_SK = SW'(STACK_COUNT - 1);

  mssp_pkg::state_t  state_r, state_nxt;

  // configuration
  logic [mssp_pkg::CFG_W-1:0] cap_r, sin_r;

  // latched item
  logic                       func_r;
  logic [mssp_pkg::SN_W-1:0]  sn_r;
  logic [mssp_pkg::VAL_W-1:0] val_r;

  // list bookkeeping
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] next_unused_r, next_unused_nxt;
  logic [PW-1:0] held_r, held_nxt;
  logic [PW-1:0] peak_r, peak_nxt;
  logic          err_r, err_nxt;
  logic [SW-1:0] clr_cnt_r, clr_cnt_nxt;
  mssp_pkg::status_t status_r, status_nxt;

  // stack head memory, registered read
  logic [PW-1:0] top_mem [STACK_COUNT];
  logic [PW-1:0] top_rd_r;
  logic          top_we;
  logic [SW-1:0] top_waddr;
  logic [PW-1:0] top_wdata;
  logic [SW-1:0] idx;

  // pool port
  mssp_pkg::pool_ctl_t        pool_ctl;
  logic [AW-1:0]              pool_waddr, pool_raddr;
  logic [PW-1:0]              pool_wbelow, pool_rbelow;
  logic [mssp_pkg::VAL_W-1:0] pool_rvalue;

  // result register
  logic                        out_valid_r;
  logic                        out_load;
  logic [mssp_pkg::STAT_W-1:0] out_status_r;
  logic [mssp_pkg::CNT_W-1:0]  out_occ_r, out_peak_r;
  logic                        out_err_r, out_clean_r;

  // decisions of the current item
  logic          accept;
  logic          bad_stack, pool_full, top_empty, top_mismatch, use_free;
  logic [PW-1:0] new_entry;

  assign idx          = SW'(32'(sn_r) - 32'd1);
  assign accept       = in_chan.valid && in_chan.ready;
  assign bad_stack    = (sn_r == '0) || (32'(sn_r) > 32'(sin_r))
                        || (32'(sn_r) > 32'(STACK_COUNT));
  assign pool_full    = (32'(held_r) >= 32'(cap_r)) || (32'(held_r) >= 32'(POOL_DEPTH));
  assign top_empty    = (top_rd_r >= EMPTY);
  assign top_mismatch = (pool_rvalue != val_r);
  assign use_free     = (free_head_r < EMPTY);
  assign new_entry    = use_free ? free_head_r : next_unused_r;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mssp_pkg::ST_CLEAR: begin
        if (clr_cnt_r == LAST_SK) begin
          state_nxt = mssp_pkg::ST_IDLE;
        end
      end
      mssp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = mssp_pkg::ST_CHECK;
        end
      end
      mssp_pkg::ST_CHECK: begin
        if (err_r || bad_stack || ((func_r == mssp_pkg::FUNC_PUSH) && pool_full)) begin
          state_nxt = mssp_pkg::ST_DONE;
        end else begin
          state_nxt = mssp_pkg::ST_TOP;
        end
      end
      mssp_pkg::ST_TOP: begin
        if ((func_r == mssp_pkg::FUNC_PUSH) || top_empty) begin
          state_nxt = mssp_pkg::ST_DONE;
        end else begin
          state_nxt = mssp_pkg::ST_POP;
        end
      end
      mssp_pkg::ST_POP: begin
        state_nxt = mssp_pkg::ST_DONE;
      end
      mssp_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = mssp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mssp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: memory controls and bookkeeping updates
  // ---------------------------------------------------------------------------
  always_comb begin
    in_chan.ready   = 1'b0;
    out_load        = 1'b0;
    top_we          = 1'b0;
    top_waddr       = idx;
    top_wdata       = new_entry;
    pool_ctl        = '0;
    pool_waddr      = new_entry[AW-1:0];
    pool_wbelow     = top_rd_r;
    // pool read: free-list link while checking, the popped entry afterwards
    pool_raddr      = (state_r == mssp_pkg::ST_CHECK) ? free_head_r[AW-1:0]
                                                      : top_rd_r[AW-1:0];
    free_head_nxt   = free_head_r;
    next_unused_nxt = next_unused_r;
    held_nxt        = held_r;
    peak_nxt        = peak_r;
    err_nxt         = err_r;
    status_nxt      = status_r;
    clr_cnt_nxt     = clr_cnt_r;

    unique case (state_r)
      mssp_pkg::ST_CLEAR: begin
        top_we      = 1'b1;
        top_waddr   = clr_cnt_r;
        top_wdata   = EMPTY;
        clr_cnt_nxt = clr_cnt_r + SW'(1);
      end
      mssp_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
      end
      mssp_pkg::ST_CHECK: begin
        status_nxt = mssp_pkg::STAT_OK;
        if (err_r) begin
          status_nxt = mssp_pkg::STAT_IGNORED;
        end else if (bad_stack) begin
          status_nxt = mssp_pkg::STAT_BAD_STACK;
          err_nxt    = 1'b1;
        end else if ((func_r == mssp_pkg::FUNC_PUSH) && pool_full) begin
          status_nxt = mssp_pkg::STAT_FULL;
          err_nxt    = 1'b1;
        end
      end
      mssp_pkg::ST_TOP: begin
        if (func_r == mssp_pkg::FUNC_PUSH) begin
          // link the new entry above the old head
          top_we            = 1'b1;
          pool_ctl.wr_en    = 1'b1;
          pool_ctl.wr_value = 1'b1;
          if (use_free) begin
            free_head_nxt = pool_rbelow;
          end else begin
            next_unused_nxt = next_unused_r + PW'(1);
          end
          held_nxt = held_r + PW'(1);
          if (held_r + PW'(1) > peak_r) begin
            peak_nxt = held_r + PW'(1);
          end
        end else if (top_empty) begin
          status_nxt = mssp_pkg::STAT_EMPTY;
          err_nxt    = 1'b1;
        end
      end
      mssp_pkg::ST_POP: begin
        if (top_mismatch) begin
          status_nxt = mssp_pkg::STAT_MISMATCH;
          err_nxt    = 1'b1;
        end else begin
          // unlink the head and push it onto the free list
          top_we         = 1'b1;
          top_wdata      = pool_rbelow;
          pool_ctl.wr_en = 1'b1;
          pool_waddr     = top_rd_r[AW-1:0];
          pool_wbelow    = free_head_r;
          free_head_nxt  = top_rd_r;
          if (held_r != '0) begin
            held_nxt = held_r - PW'(1);
          end
        end
      end
      mssp_pkg::ST_DONE: begin
        out_load = !out_valid_r || out_chan.ready;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stack head memory
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (top_we) begin
      top_mem[top_waddr] <= top_wdata;
    end
    top_rd_r <= top_mem[idx];
  end

  mssp_pool #(
    .DEPTH (POOL_DEPTH),
    .AW    (AW),
    .PW    (PW)
  ) u_pool (
    .clk      (clk),
    .ctl      (pool_ctl),
    .wr_addr  (pool_waddr),
    .wr_value (val_r),
    .wr_below (pool_wbelow),
    .rd_addr  (pool_raddr),
    .rd_value (pool_rvalue),
    .rd_below (pool_rbelow)
  );

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mssp_pkg::ST_CLEAR;
      clr_cnt_r     <= '0;
      cap_r         <= mssp_pkg::CFG_RESET;
      sin_r         <= mssp_pkg::CFG_RESET;
      free_head_r   <= EMPTY;
      next_unused_r <= '0;
      held_r        <= '0;
      peak_r        <= '0;
      err_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      free_head_r   <= free_head_nxt;
      next_unused_r <= next_unused_nxt;
      held_r        <= held_nxt;
      peak_r        <= peak_nxt;
      err_r         <= err_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          mssp_pkg::CFG_CAPACITY: cap_r <= cfg_wdata;
          mssp_pkg::CFG_STACKS:   sin_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (accept) begin
      func_r <= in_chan.func;
      sn_r   <= in_chan.stack_number;
      val_r  <= in_chan.item_value;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_occ_r    <= mssp_pkg::CNT_W'(held_r);
      out_peak_r   <= mssp_pkg::CNT_W'(peak_r);
      out_err_r    <= err_r;
      out_clean_r  <= !err_r && (held_r == '0);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.occupancy      = out_occ_r;
  assign out_chan.peak_occupancy = out_peak_r;
  assign out_chan.error_latched  = out_err_r;
  assign out_chan.clean_finish   = out_clean_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MSSP_ASSERT_NEXT(a_err_sticky, err_r, err_r, "error latch cleared without reset")
  `MSSP_ASSERT_NEXT(a_accept_check, accept, state_r == mssp_pkg::ST_CHECK, "accepted item not checked next")
  `MSSP_ASSERT(a_peak_ge_held, peak_r >= held_r, "peak occupancy below occupancy")
  `MSSP_ASSERT(a_held_le_alloc, held_r <= next_unused_r, "more values held than entries ever used")
  `MSSP_ASSERT(a_no_accept_busy, !(accept && (state_r != mssp_pkg::ST_IDLE)), "item taken while busy")

endmodule
